[design/cbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Sizes, address windows and access codes shared by the mapper design.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int MAX_RAM_BANKS  = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BITS  = 7;

    localparam int STORE_BYTES    = MAX_RAM_BANKS * RAM_BANK_BYTES;
    localparam int STORE_ADDR_W   = $clog2(STORE_BYTES);
    localparam int RAM_OFFSET_W   = $clog2(RAM_BANK_BYTES);
    localparam int BANK_SEL_W     = STORE_ADDR_W - RAM_OFFSET_W;
    localparam int ROM_OFFSET_W   = 14;
    localparam int ROM_ADDR_W     = ROM_BANK_BITS + ROM_OFFSET_W;
    localparam int COUNT_W        = 3;
    localparam int BUS_ADDR_W     = 16;
    localparam int WINDOW_W       = BUS_ADDR_W - RAM_OFFSET_W;

    localparam logic [ROM_BANK_BITS-1:0] ROM_BANK_MASK =
        ROM_BANK_BITS'((1 << ROM_BANK_BITS) - 1);
    localparam logic [ROM_BANK_BITS-1:0] ROM_BANK_ONE = ROM_BANK_BITS'(1);

    localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // 8 KiB windows of the CPU bus, taken from the top three address bits.
    typedef enum logic [WINDOW_W-1:0] {
        WIN_RAM_ENABLE = 3'd0,
        WIN_ROM_BANK   = 3'd1,
        WIN_RAM_BANK   = 3'd2,
        WIN_CLOCK      = 3'd3,
        WIN_VIDEO      = 3'd4,
        WIN_EXT_RAM    = 3'd5,
        WIN_WORK_RAM   = 3'd6,
        WIN_HIGH       = 3'd7
    } window_t;

endpackage

[design/cartridge_bank_mapper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper unit
// Decodes CPU bus accesses into bank register updates, banked RAM accesses
// and physical ROM addresses.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one bus access per
// transfer: command, bus_address and write_byte. The output channel
// (out_valid, out_stall) returns exactly one result per access, in order:
// read_byte, rom_address, rom_read and claimed. The configuration port sets
// the number of RAM banks present with cfg_write_enable and cfg_write_data.
// Each result is registered and appears in the cycle after its transfer, and one
// access can be taken in every cycle while in_stall is low; the read port of
// the banked RAM registers its data at the output.
// Bank registers and RAM writes take effect at the transfer edge, so the next
// access already sees them.
// After reset the RAM is filled with 0xFF, one byte a cycle, over all 32768
// bytes; in_stall stays high during that pass. Configuration writes are
// taken at any time. When the receiver stalls, the result is held and a new
// access is taken only in the cycle in which the held one leaves.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit
    import cbm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [COUNT_W-1:0]       cfg_write_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [BUS_ADDR_W-1:0]    bus_address,
    input  logic [7:0]               write_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               read_byte,
    output logic [ROM_ADDR_W-1:0]    rom_address,
    output logic                     rom_read,
    output logic                     claimed
);

    logic [7:0]               ram_mem [STORE_BYTES];
    logic [7:0]               mem_rdata_reg;

    logic [COUNT_W-1:0]       bank_count_reg;
    logic                     ram_enabled_reg;
    logic                     ram_enabled_next;
    logic [ROM_BANK_BITS-1:0] rom_bank_reg;
    logic [ROM_BANK_BITS-1:0] rom_bank_next;
    logic [7:0]               ram_bank_reg;
    logic [7:0]               ram_bank_next;

    logic                     clear_busy_reg;
    logic [STORE_ADDR_W-1:0]  clear_addr_reg;

    logic                     out_valid_reg;
    logic                     out_ram_sel_reg;
    logic                     out_ram_sel_next;
    logic [ROM_ADDR_W-1:0]    out_rom_addr_reg;
    logic [ROM_ADDR_W-1:0]    out_rom_addr_next;
    logic                     out_rom_read_reg;
    logic                     out_rom_read_next;
    logic                     out_claimed_reg;
    logic                     out_claimed_next;

    logic                     in_accept;
    window_t                  window;
    logic [COUNT_W-1:0]       banks_present;
    logic                     bank_present;
    logic [STORE_ADDR_W-1:0]  store_addr;
    logic [ROM_BANK_BITS-1:0] rom_bank_sel;
    logic                     mem_we;
    logic [STORE_ADDR_W-1:0]  mem_waddr;
    logic [7:0]               mem_wdata;
    logic                     mem_re;

    assign in_stall  = clear_busy_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign window        = window_t'(bus_address[BUS_ADDR_W-1:RAM_OFFSET_W]);
    assign banks_present = (bank_count_reg > COUNT_W'(MAX_RAM_BANKS))
                           ? COUNT_W'(MAX_RAM_BANKS) : bank_count_reg;
    assign bank_present  = ram_bank_reg < {{(8-COUNT_W){1'b0}}, banks_present};
    assign store_addr    = {ram_bank_reg[BANK_SEL_W-1:0],
                            bus_address[RAM_OFFSET_W-1:0]};
    assign rom_bank_sel  = write_byte[ROM_BANK_BITS-1:0] & ROM_BANK_MASK;

    always_comb
    begin
        ram_enabled_next  = ram_enabled_reg;
        rom_bank_next     = rom_bank_reg;
        ram_bank_next     = ram_bank_reg;
        out_ram_sel_next  = 1'b0;
        out_rom_addr_next = '0;
        out_rom_read_next = 1'b0;
        out_claimed_next  = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;

        unique case (window) inside
            WIN_RAM_ENABLE, WIN_ROM_BANK, WIN_RAM_BANK, WIN_CLOCK, WIN_EXT_RAM:
            begin
                out_claimed_next = 1'b1;
            end
            default:
            begin
                out_claimed_next = 1'b0;
            end
        endcase

        if (command == CMD_WRITE)
        begin
            unique case (window) inside
                WIN_RAM_ENABLE:
                begin
                    ram_enabled_next = write_byte[3] || write_byte[1];
                end
                WIN_ROM_BANK:
                begin
                    rom_bank_next = (rom_bank_sel == '0) ? ROM_BANK_ONE : rom_bank_sel;
                end
                WIN_RAM_BANK:
                begin
                    ram_bank_next = write_byte;
                end
                WIN_EXT_RAM:
                begin
                    mem_we = ram_enabled_reg && bank_present;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (window) inside
                WIN_RAM_ENABLE, WIN_ROM_BANK:
                begin
                    out_rom_read_next = 1'b1;
                    out_rom_addr_next = {{ROM_BANK_BITS{1'b0}},
                                         bus_address[ROM_OFFSET_W-1:0]};
                end
                WIN_RAM_BANK, WIN_CLOCK:
                begin
                    out_rom_read_next = 1'b1;
                    out_rom_addr_next = {rom_bank_reg, bus_address[ROM_OFFSET_W-1:0]};
                end
                WIN_EXT_RAM:
                begin
                    out_ram_sel_next = bank_present;
                    mem_re           = bank_present;
                end
                default:
                begin
                end
            endcase
        end

        mem_we = mem_we && in_accept;
        mem_re = mem_re && in_accept;
    end

    assign mem_waddr = clear_busy_reg ? clear_addr_reg : store_addr;
    assign mem_wdata = clear_busy_reg ? OPEN_BUS_BYTE : write_byte;

    always_ff @(posedge clk)
    begin
        if (mem_we || clear_busy_reg)
        begin
            ram_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= ram_mem[store_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + STORE_ADDR_W'(1);
            if (clear_addr_reg == STORE_ADDR_W'(STORE_BYTES - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg <= COUNT_W'(MAX_RAM_BANKS);
        end
        else if (cfg_write_enable)
        begin
            bank_count_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg <= 1'b0;
            rom_bank_reg    <= ROM_BANK_ONE;
            ram_bank_reg    <= '0;
        end
        else if (in_accept)
        begin
            ram_enabled_reg <= ram_enabled_next;
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_ram_sel_reg  <= out_ram_sel_next;
            out_rom_addr_reg <= out_rom_addr_next;
            out_rom_read_reg <= out_rom_read_next;
            out_claimed_reg  <= out_claimed_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_byte   = out_ram_sel_reg ? mem_rdata_reg : OPEN_BUS_BYTE;
    assign rom_address = out_rom_addr_reg;
    assign rom_read    = out_rom_read_reg;
    assign claimed     = out_claimed_reg;

    a_rom_bank_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        rom_bank_reg != '0)
        else $error("Switchable ROM bank register holds bank zero.");

    a_result_follows_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("Accepted access gave no result in the next cycle.");

    a_ram_result_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ram_sel_reg) |-> (!out_rom_read_reg && out_claimed_reg))
        else $error("RAM result also marked as a ROM read or unclaimed.");

    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !out_valid_reg)
        else $error("Result presented while the RAM fill pass runs.");

endmodule
